// ----- sv/cfla_pkg.sv -----
// Shared types and codes for the chunked free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

package cfla_pkg;

	// Command function codes.
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_CHUNK = 2'd1;
	localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

	// One command beat.
	typedef struct packed {
		logic       func;
		logic [2:0] node_chunk;
		logic [8:0] node_slot;
	} cfla_cmd_t;

	// One result beat.
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] got_chunk;
		logic [8:0] got_slot;
		logic       chunk_created;
		logic       chunk_released;
	} cfla_result_t;

endpackage

`default_nettype wire

// ----- sv/chunked_free_list_allocator.sv -----
// Top level of the chunked free-list node allocator.
//
// Usage: a command beat (allocate or free) is taken on a rising edge with start
// high and busy low. Except for a bad free, busy then stays high while a small
// sequencer works on it, and the single result beat appears on result with done
// high for one cycle. The receiver cannot stall; a new command may be started in
// the same cycle that done is shown.
// Steps: a bad free is answered straight from idle, without busy going high. A
// good free writes the link RAM and, when its chunk is released, then walks the
// active-chunk order list from the back, shifting entries over the released one.
// An allocate scans the order list newest first until a chunk with a free slot
// is found, activating the lowest inactive chunk if none is, then either hands
// out a never-used slot or reads the link RAM to pop from the linked free list.
// The scan through the order list and the registered read of the link RAM set
// how long a command takes.
// Reset: every chunk is inactive and all free lists are empty; the link RAM is
// not cleared since a link is always written by a free before it is read.
`timescale 1ns / 1ps
`default_nettype none

module chunked_free_list_allocator
	import cfla_pkg::*;
#(
	parameter int SLOTS_PER_CHUNK = 512,
	parameter int CHUNK_COUNT     = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire cfla_cmd_t    cmd,
	output      logic         busy,
	output      logic         done,
	output      cfla_result_t result
);

	localparam int SW  = $clog2(SLOTS_PER_CHUNK + 1);
	localparam int SIW = $clog2(SLOTS_PER_CHUNK);
	localparam int CW  = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
	localparam int NW  = $clog2(CHUNK_COUNT + 1);
	localparam int DEPTH = CHUNK_COUNT * SLOTS_PER_CHUNK;
	localparam int AW  = $clog2(DEPTH);
	localparam logic [SW-1:0] NULL_LINK = SW'(SLOTS_PER_CHUNK);

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_POP  = 3'd2;
	localparam logic [2:0] ST_POPW = 3'd3;
	localparam logic [2:0] ST_FREE = 3'd4;
	localparam logic [2:0] ST_REL  = 3'd5;

	logic [2:0]     state_q;
	logic [CW-1:0]  cur_q;
	logic [SIW-1:0] slot_q;
	logic [NW-1:0]  pos_q;
	logic [CW-1:0]  carry_q;
	logic           created_q;
	logic           done_q;
	cfla_result_t   result_q;

	logic [SW-1:0]  head_q  [CHUNK_COUNT];
	logic [SW-1:0]  fresh_q [CHUNK_COUNT];
	logic [SW-1:0]  used_q  [CHUNK_COUNT];
	logic [CW-1:0]  order_q [CHUNK_COUNT];
	logic [CHUNK_COUNT-1:0] active_q;
	logic [CHUNK_COUNT-1:0] avail_q;
	logic [NW-1:0]  total_q;

	logic [CW-1:0]  pidx;
	logic [CW-1:0]  cand;
	logic           walk_more;
	logic [CW-1:0]  low_pick;
	logic           any_inactive;
	logic [SW-1:0]  hd;
	logic [SW-1:0]  fr;
	logic [SW-1:0]  us;
	logic [SW-1:0]  used_dec;
	logic [CW-1:0]  cmd_cidx;
	logic           cmd_ok;
	logic           fin;
	cfla_result_t   fin_result;

	logic           ram_we;
	logic           ram_re;
	logic [AW-1:0]  ram_waddr;
	logic [AW-1:0]  ram_raddr;
	logic [SW-1:0]  ram_rdata;

	// Link memory: the next slot of each chunk's explicit free list.
	cfla_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_links (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(hd),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Reads of the per-chunk registers for the current chunk and scan position.
	assign pidx      = pos_q[CW-1:0];
	assign cand      = order_q[pidx];
	assign walk_more = (pos_q < total_q);
	assign hd        = head_q[cur_q];
	assign fr        = fresh_q[cur_q];
	assign us        = used_q[cur_q];
	assign used_dec  = (us == '0) ? '0 : us - SW'(1);
	assign any_inactive = ~&active_q;

	// Lowest inactive chunk.
	always_comb begin
		low_pick = '0;
		for (int i = CHUNK_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				low_pick = CW'(i);
			end
		end
	end

	// A free must name an active chunk and an existing slot.
	assign cmd_cidx = CW'(cmd.node_chunk);
	assign cmd_ok   = (int'(cmd.node_chunk) < CHUNK_COUNT) &&
		(int'(cmd.node_slot) < SLOTS_PER_CHUNK) && active_q[cmd_cidx];

	// Link RAM port control: push on a free, read the list head on a pop.
	assign ram_we    = (state_q == ST_FREE);
	assign ram_re    = (state_q == ST_POP) && (hd != NULL_LINK);
	assign ram_waddr = AW'(int'(cur_q) * SLOTS_PER_CHUNK + int'(slot_q));
	assign ram_raddr = AW'(int'(cur_q) * SLOTS_PER_CHUNK + int'(hd));

	// Completion of a command and its result beat.
	always_comb begin
		fin        = 1'b0;
		fin_result = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && cmd.func == FUNC_FREE && !cmd_ok) begin
					fin               = 1'b1;
					fin_result.status = STATUS_BAD_FREE;
				end
			end
			ST_WALK: begin
				if (!walk_more && !any_inactive) begin
					fin               = 1'b1;
					fin_result.status = STATUS_NO_CHUNK;
				end
			end
			ST_POP: begin
				if (hd == NULL_LINK) begin
					fin                      = 1'b1;
					fin_result.got_chunk     = 3'(cur_q);
					fin_result.got_slot      = 9'(fr);
					fin_result.chunk_created = created_q;
				end
			end
			ST_POPW: begin
				fin                      = 1'b1;
				fin_result.got_chunk     = 3'(cur_q);
				fin_result.got_slot      = 9'(hd);
				fin_result.chunk_created = created_q;
			end
			ST_FREE: begin
				fin = (used_dec != '0);
			end
			ST_REL: begin
				if (cand == cur_q) begin
					fin                       = 1'b1;
					fin_result.chunk_released = 1'b1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Sequencer and per-chunk bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			slot_q    <= '0;
			pos_q     <= '0;
			carry_q   <= '0;
			created_q <= 1'b0;
			done_q    <= 1'b0;
			active_q  <= '0;
			avail_q   <= '0;
			total_q   <= '0;
			for (int i = 0; i < CHUNK_COUNT; i++) begin
				head_q[i]  <= NULL_LINK;
				fresh_q[i] <= '0;
				used_q[i]  <= '0;
				order_q[i] <= '0;
			end
		end else begin
			done_q <= fin;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						created_q <= 1'b0;
						if (cmd.func == FUNC_ALLOC) begin
							pos_q   <= '0;
							state_q <= ST_WALK;
						end else if (cmd_ok) begin
							cur_q   <= cmd_cidx;
							slot_q  <= SIW'(cmd.node_slot);
							state_q <= ST_FREE;
						end
					end
				end
				ST_WALK: begin
					if (walk_more) begin
						// Newest-first scan for a chunk with a free slot.
						if (avail_q[cand]) begin
							cur_q   <= cand;
							state_q <= ST_POP;
						end else begin
							pos_q <= pos_q + NW'(1);
						end
					end else if (any_inactive) begin
						// Activate the lowest unused chunk at the front of the order.
						for (int i = 1; i < CHUNK_COUNT; i++) begin
							order_q[i] <= order_q[i-1];
						end
						order_q[0]         <= low_pick;
						total_q            <= total_q + NW'(1);
						active_q[low_pick] <= 1'b1;
						avail_q[low_pick]  <= 1'b1;
						head_q[low_pick]   <= NULL_LINK;
						fresh_q[low_pick]  <= '0;
						used_q[low_pick]   <= '0;
						cur_q              <= low_pick;
						created_q          <= 1'b1;
						state_q            <= ST_POP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					if (hd != NULL_LINK) begin
						state_q <= ST_POPW;
					end else begin
						// Hand out the next never-used slot.
						fresh_q[cur_q] <= fr + SW'(1);
						used_q[cur_q]  <= us + SW'(1);
						avail_q[cur_q] <= ((fr + SW'(1)) < NULL_LINK);
						state_q        <= ST_IDLE;
					end
				end
				ST_POPW: begin
					// Link data has arrived: unlink the head.
					head_q[cur_q]  <= ram_rdata;
					used_q[cur_q]  <= us + SW'(1);
					avail_q[cur_q] <= (ram_rdata != NULL_LINK) || (fr < NULL_LINK);
					state_q        <= ST_IDLE;
				end
				ST_FREE: begin
					head_q[cur_q]  <= SW'(slot_q);
					used_q[cur_q]  <= used_dec;
					avail_q[cur_q] <= 1'b1;
					if (used_dec == '0) begin
						active_q[cur_q] <= 1'b0;
						pos_q           <= total_q - NW'(1);
						carry_q         <= cur_q;
						state_q         <= ST_REL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_REL: begin
					// Walk down the order list, shifting entries over the released one.
					order_q[pidx] <= carry_q;
					carry_q       <= cand;
					if (cand == cur_q) begin
						total_q <= total_q - NW'(1);
						state_q <= ST_IDLE;
					end else begin
						pos_q <= pos_q - NW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= fin_result;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- sv/cfla_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/cfla_checker.sv -----
// Port-level checker for the chunked free-list allocator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module cfla_checker
	import cfla_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         start,
	input wire cfla_cmd_t    cmd,
	input wire logic         busy,
	input wire logic         done,
	input wire cfla_result_t result
);

	// A result beat only comes once the sequencer is free again.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result beat while busy");

	// Every accepted command either starts work or answers at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither started nor answered");

	// Finishing work always produces a result beat.
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> done)
		else $error("work ended without a result beat");

	// A result beat answers a command that was accepted or in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result beat without a command");

	// A failed allocate or bad free hands out nothing, and only a good free releases.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STATUS_OK) |->
		(result.got_slot == '0 && !result.chunk_created && !result.chunk_released))
		else $error("failed command carries allocation data");

endmodule

bind chunked_free_list_allocator cfla_checker u_cfla_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.cmd   (cmd),
	.busy  (busy),
	.done  (done),
	.result(result)
);

`default_nettype wire
